// File: src/hhlt_pkg.sv
// Shared types and constants of the HTTP header line tokenizer.
package hhlt_pkg;

   localparam logic [2:0] KIND_KEY_CHAR  = 3'd0;
   localparam logic [2:0] KIND_KEY_DONE  = 3'd1;
   localparam logic [2:0] KIND_VAL_CHAR  = 3'd2;
   localparam logic [2:0] KIND_LINE_DONE = 3'd3;
   localparam logic [2:0] KIND_HDRS_DONE = 3'd4;
   localparam logic [2:0] KIND_MALFORMED = 3'd5;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [1:0] {
      PH_START,
      PH_KEY,
      PH_SKIP,
      PH_VALUE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY2,
      ST_EVICT,
      ST_FLUSH,
      ST_FINAL
   } back_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lower;
      logic       is_lf;
      logic       is_cr;
      logic       is_colon;
      logic       is_ws;
   } item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      phase_type phase;
      logic      flushing;
      logic      held_empty;
   } stat_type;

endpackage

// File: src/hhlt_if.sv
// Valid/ready channel interfaces for the byte input and the token output.
interface hhlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface hhlt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_kind, output out_byte, output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

// File: src/http_header_line_tokenizer.sv
// Top level of the HTTP header line tokenizer.
// Takes one header byte per transfer and produces key, value and line tokens, with key
// characters lowercased, leading value whitespace skipped and trailing whitespace dropped.
// A byte that yields at most one token, or none, is handled in ST_IDLE alone. A CR at line
// start followed by a key byte passes through ST_KEY2, and a whitespace byte that pushes
// out the oldest held byte through ST_EVICT. A non-space value byte after held whitespace
// passes through ST_FLUSH, reading the held-whitespace RAM one entry per cycle unless the
// output stalls, then ST_FINAL. A two-entry queue lets the input take up to two more bytes
// meanwhile. The back end stalls while a token waits in the output register to be taken.
module http_header_line_tokenizer
   import hhlt_pkg::*;
#(
   parameter int HELD_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   hhlt_req_if.sink   req_ch,
   hhlt_rsp_if.source rsp_ch
);

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop;
   logic     q_valid;
   item_type q_item;
   stat_type stat;

   hhlt_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   hhlt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .valid     (q_valid),
      .head_item (q_item)
   );

   hhlt_back #(
      .HELD_DEPTH (HELD_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .pop     (pop),
      .rsp_ch  (rsp_ch),
      .stat    (stat)
   );

   // Whitespace is only ever held while inside a value.
   a_held_only_in_value: assert property (@(posedge clock) disable iff (reset)
      (stat.phase != PH_VALUE) |-> stat.held_empty)
      else $error("held whitespace outside of a value");

   a_flush_not_empty: assert property (@(posedge clock) disable iff (reset)
      stat.flushing |-> !stat.held_empty)
      else $error("flushing an empty whitespace store");

   a_hdrs_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_kind == KIND_HDRS_DONE) |->
         (stat.phase == PH_START && stat.held_empty))
      else $error("headers done while line state is not cleared");

endmodule

// File: src/hhlt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hhlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hhlt_front.sv
// Front end: accepts raw bytes and classifies them for the back end.
module hhlt_front
   import hhlt_pkg::*;
(
   hhlt_req_if.sink   req_ch,
   input  logic       queue_full,
   output logic       push,
   output item_type   push_item
);

   function automatic item_type classify(input logic [7:0] b);
      item_type it;
      it.data     = b;
      it.lower    = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
      it.is_lf    = (b == CH_LF);
      it.is_cr    = (b == CH_CR);
      it.is_colon = (b == CH_COLON);
      it.is_ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                    (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
      return it;
   endfunction

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;
   assign push_item    = classify(req_ch.in_byte);

endmodule

// File: src/hhlt_queue.sv
// Two-entry queue of classified bytes between the front and back ends.
module hhlt_queue
   import hhlt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head_item
);

   item_type   entry_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;

   assign full      = (count_ff == 2'd2);
   assign valid     = (count_ff != 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/hhlt_back.sv
// Back end: line-phase state machine, held-whitespace store and token output register.
module hhlt_back
   import hhlt_pkg::*;
#(
   parameter int HELD_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  item_type  q_item,
   output logic      pop,
   hhlt_rsp_if.source rsp_ch,
   output stat_type  stat
);

   localparam int PTR_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
   localparam int CNT_W = $clog2(HELD_DEPTH + 1);

   back_state_type   state_ff;
   back_state_type   state_in;
   phase_type        phase_ff;
   phase_type        phase_in;
   logic             held_cr_ff;
   logic             held_cr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   item_type         cur_ff;
   item_type         cur_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_type          out_ff;
   rsp_type          out_in;

   logic             out_free;
   logic             take;
   logic             held_full;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic             ram_we;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [PTR_W-1:0] ram_raddr;
   logic [7:0]       ram_rdata;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(HELD_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic rsp_type key_rsp(input item_type it);
      rsp_type r;
      if (it.is_colon) begin
         r = '{kind: KIND_KEY_DONE, data: 8'h00, last: 1'b1};
      end else if (it.is_lf) begin
         r = '{kind: KIND_MALFORMED, data: 8'h00, last: 1'b1};
      end else begin
         r = '{kind: KIND_KEY_CHAR, data: it.lower, last: 1'b1};
      end
      return r;
   endfunction

   function automatic phase_type key_phase(input item_type it);
      phase_type p;
      if (it.is_colon) begin
         p = PH_SKIP;
      end else if (it.is_lf) begin
         p = PH_START;
      end else begin
         p = PH_KEY;
      end
      return p;
   endfunction

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign take      = (state_ff == ST_IDLE) && q_valid && out_free;
   assign held_full = (count_ff == CNT_W'(HELD_DEPTH));
   assign head_next = wrap_inc(head_ff);
   assign tail_next = wrap_inc(tail_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (phase_ff == PH_START && !q_item.is_lf && held_cr_ff) begin
                  state_in = ST_KEY2;
               end else if (phase_ff == PH_VALUE && !q_item.is_lf) begin
                  if (q_item.is_ws && held_full) begin
                     state_in = ST_EVICT;
                  end else if (!q_item.is_ws && count_ff != '0) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_KEY2: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EVICT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free && count_ff == CNT_W'(1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      phase_in     = phase_ff;
      held_cr_in   = held_cr_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = cur_ff.data;
      ram_re       = 1'b0;
      ram_raddr    = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               pop    = 1'b1;
               cur_in = q_item;
               case (phase_ff)
                  PH_START: begin
                     if (q_item.is_lf) begin
                        out_valid_in = 1'b1;
                        out_in       = '{kind: KIND_HDRS_DONE, data: 8'h00, last: 1'b1};
                        held_cr_in   = 1'b0;
                        count_in     = '0;
                        head_in      = '0;
                        tail_in      = '0;
                     end else if (held_cr_ff) begin
                        // The held CR turns out to be part of a key.
                        held_cr_in   = 1'b0;
                        out_valid_in = 1'b1;
                        out_in       = '{kind: KIND_KEY_CHAR, data: CH_CR, last: 1'b0};
                        phase_in     = PH_KEY;
                     end else if (q_item.is_cr) begin
                        held_cr_in = 1'b1;
                     end else begin
                        out_valid_in = 1'b1;
                        out_in       = key_rsp(q_item);
                        phase_in     = key_phase(q_item);
                     end
                  end
                  PH_KEY: begin
                     out_valid_in = 1'b1;
                     out_in       = key_rsp(q_item);
                     phase_in     = key_phase(q_item);
                  end
                  PH_SKIP: begin
                     if (q_item.is_lf) begin
                        out_valid_in = 1'b1;
                        out_in       = '{kind: KIND_LINE_DONE, data: 8'h00, last: 1'b1};
                        phase_in     = PH_START;
                     end else if (!q_item.is_ws) begin
                        out_valid_in = 1'b1;
                        out_in       = '{kind: KIND_VAL_CHAR, data: q_item.data, last: 1'b1};
                        phase_in     = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     if (q_item.is_lf) begin
                        out_valid_in = 1'b1;
                        out_in       = '{kind: KIND_LINE_DONE, data: 8'h00, last: 1'b1};
                        phase_in     = PH_START;
                        count_in     = '0;
                        head_in      = '0;
                        tail_in      = '0;
                     end else if (q_item.is_ws) begin
                        if (held_full) begin
                           ram_re = 1'b1;
                        end else begin
                           ram_we    = 1'b1;
                           ram_wdata = q_item.data;
                           tail_in   = tail_next;
                           count_in  = count_ff + CNT_W'(1);
                        end
                     end else if (count_ff == '0) begin
                        out_valid_in = 1'b1;
                        out_in       = '{kind: KIND_VAL_CHAR, data: q_item.data, last: 1'b1};
                     end else begin
                        ram_re = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_START;
                  end
               endcase
            end
         end
         ST_KEY2: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = key_rsp(cur_ff);
               phase_in     = key_phase(cur_ff);
            end
         end
         ST_EVICT: begin
            // Store is full, so the tail slot is the one just read out.
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{kind: KIND_VAL_CHAR, data: ram_rdata, last: 1'b1};
               ram_we       = 1'b1;
               ram_wdata    = cur_ff.data;
               head_in      = head_next;
               tail_in      = tail_next;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{kind: KIND_VAL_CHAR, data: ram_rdata, last: 1'b0};
               head_in      = head_next;
               count_in     = count_ff - CNT_W'(1);
               if (count_ff != CNT_W'(1)) begin
                  ram_re    = 1'b1;
                  ram_raddr = head_next;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{kind: KIND_VAL_CHAR, data: cur_ff.data, last: 1'b1};
            end
         end
         default: begin
            out_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_START;
         held_cr_ff   <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         held_cr_ff   <= held_cr_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   hhlt_ram #(
      .WIDTH (8),
      .DEPTH (HELD_DEPTH)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_kind = out_ff.kind;
   assign rsp_ch.out_byte = out_ff.data;
   assign rsp_ch.last     = out_ff.last;

   assign stat.phase      = phase_ff;
   assign stat.flushing   = (state_ff == ST_FLUSH);
   assign stat.held_empty = (count_ff == '0);

endmodule
